FILE: rtl/max_profit_k_transactions_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for max_profit_k_transactions
// Clocked concurrent assertion wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef MAX_PROFIT_K_TRANSACTIONS_DEFINES_SVH
`define MAX_PROFIT_K_TRANSACTIONS_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define MPK_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define MPK_ASSERT(lbl, prop, msg) \
  `MPK_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/mpk_pkg.sv
// ----------------------------------------------------------------------------
// mpk_pkg
// Shared widths, types and constants of the k-transaction profit kernel.
// ----------------------------------------------------------------------------
`default_nettype none

package mpk_pkg;

  localparam int ValW            = 32;
  localparam int PriceW          = 16;
  localparam int CfgW            = 5;
  localparam int MaxTransDefault = 16;

  typedef logic [ValW-1:0]   val_t;
  typedef logic [PriceW-1:0] price_t;
  typedef logic [CfgW-1:0]   cfg_t;

  localparam cfg_t CfgResetVal = cfg_t'(2);

  // per-item control handed to every cell
  typedef struct packed {
    logic accept;
    logic first;
    logic en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/max_profit_k_transactions.sv
// ----------------------------------------------------------------------------
// max_profit_k_transactions
// Best trading profit with at most K buy-sell transactions. Feed prices one
// item at a time from the latest to the earliest; set first on the opening
// item to clear state. A chain of MaxTransactions cap cells updates in
// parallel, each cell taking the pre-item free value of the cap below it, so
// the block takes one item per cycle when not stalled and returns one result
// per item in the next cycle from the combinational cell update (saturating
// add, compare, select of cap K). K comes from the config register, clamped
// to MaxTransactions; K of zero yields zero profit. saturated is sticky until
// the next first item. Write the register only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "max_profit_k_transactions_defines.svh"

module max_profit_k_transactions
  import mpk_pkg::*;
#(
  parameter int MaxTransactions = MaxTransDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  cfg_t       cfg_wdata_i,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  price_t     price_i,
  input  wire        first_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output val_t       profit_o,
  output logic       saturated_o
);

  localparam int KW   = $clog2(MaxTransactions + 1);
  localparam int IdxW = (MaxTransactions > 1) ? $clog2(MaxTransactions) : 1;

  cfg_t            cfg_q;
  logic [KW-1:0]   k_eff, k_sel;
  logic [IdxW-1:0] k_idx;
  logic            in_acc;
  logic            any_clip;
  logic            clip_q, clip_d;
  logic            out_valid_q;
  val_t            profit_q, profit_d;

  val_t                       chain [0:MaxTransactions];
  val_t                       free_nxt [MaxTransactions];
  logic [MaxTransactions-1:0] clip_vec;
  cell_ctrl_t                 ctrl [MaxTransactions];

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;

  always_comb begin
    if (int'(cfg_q) > MaxTransactions) begin
      k_eff = KW'(MaxTransactions);
    end else begin
      k_eff = KW'(cfg_q);
    end
    k_sel = k_eff - KW'(1);
    k_idx = k_sel[IdxW-1:0];
  end

  assign chain[0] = '0;

  for (genvar c = 0; c < MaxTransactions; c++) begin : g_cell
    assign ctrl[c] = '{accept: in_acc, first: first_i, en: (k_eff > KW'(c))};

    mpk_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[c]),
      .price_i (price_i),
      .below_i (chain[c]),
      .below_o (chain[c+1]),
      .free_o  (free_nxt[c]),
      .clip_o  (clip_vec[c])
    );
  end

  assign any_clip = |clip_vec;

  always_comb begin
    profit_d = (k_eff == '0) ? '0 : free_nxt[k_idx];
    clip_d   = clip_q;
    if (in_acc) begin
      clip_d = (first_i ? 1'b0 : clip_q) | any_clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgResetVal;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clip_q <= clip_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      profit_q <= profit_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign profit_o    = profit_q;
  assign saturated_o = clip_q;

  `MPK_ASSERT(a_zero_cap_no_profit, (in_acc && k_eff == '0) |=> (out_valid_o && profit_o == '0), "zero cap gave nonzero profit")
  `MPK_ASSERT(a_first_clears_clip, (in_acc && first_i && !any_clip) |=> !saturated_o, "first item did not clear saturation")
  `MPK_ASSERT(a_clip_sticky, (in_acc && !first_i && clip_q) |=> saturated_o, "saturation flag dropped without first")
  `MPK_ASSERT(a_free_monotonic, (in_acc && !first_i && k_eff != '0) |-> (free_nxt[0] >= chain[1]), "cap one free value decreased")

endmodule

`default_nettype wire

FILE: rtl/mpk_cell.sv
// ----------------------------------------------------------------------------
// mpk_cell
// One transaction-cap cell: holds the free and holding values of its cap and
// passes its pre-item free value to the next cap up the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module mpk_cell
  import mpk_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  price_t     price_i,
  input  val_t       below_i,
  output val_t       below_o,
  output val_t       free_o,
  output logic       clip_o
);

  localparam int SumW = ValW + 1;

  val_t free_q, hold_q;
  val_t old_free, old_hold;
  val_t price_ext, sell, buy, hold_d, free_d;
  logic [SumW-1:0] sell_sum;
  logic clip;

  always_comb begin
    old_free  = ctrl_i.first ? '0 : free_q;
    old_hold  = ctrl_i.first ? '0 : hold_q;
    price_ext = ValW'(price_i);
    sell_sum  = SumW'(below_i) + SumW'(price_i);
    clip      = sell_sum[ValW];
    sell      = clip ? '1 : sell_sum[ValW-1:0];
    hold_d    = (sell > old_hold) ? sell : old_hold;
    // a negative buy candidate never beats a free value
    buy       = (old_hold >= price_ext) ? (old_hold - price_ext) : '0;
    free_d    = (buy > old_free) ? buy : old_free;
  end

  assign below_o = old_free;
  assign free_o  = free_d;
  assign clip_o  = ctrl_i.en & clip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '0;
      hold_q <= '0;
    end else if (ctrl_i.accept && ctrl_i.en) begin
      free_q <= free_d;
      hold_q <= hold_d;
    end else if (ctrl_i.accept && ctrl_i.first) begin
      free_q <= '0;
      hold_q <= '0;
    end
  end

endmodule

`default_nettype wire
